FILE: hdl/alt_pkg.sv
// package for the audio level tracker: sizes, register codes, sequencer states, damping helper
package alt_pkg;

  localparam int WINDOW_DEPTH = 60;
  localparam int SAMPLE_BITS  = 10;
  localparam int WIDE_BITS    = SAMPLE_BITS + 1;
  localparam int IDX_W        = $clog2(WINDOW_DEPTH);
  localparam int CNT_W        = $clog2(WINDOW_DEPTH + 1);
  localparam int IN_W         = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = 3 * SAMPLE_BITS + WIDE_BITS;
  localparam int OUT_W        = ((OUT_FIELDS_W + 7) / 8) * 8;
  localparam int ADDR_W       = 4;

  localparam logic [SAMPLE_BITS-1:0] SMOOTH_RESET  = SAMPLE_BITS'(10);
  localparam logic [SAMPLE_BITS-1:0] NOISE_RESET   = SAMPLE_BITS'(10);
  localparam logic [SAMPLE_BITS-1:0] SPREAD_RESET  = SAMPLE_BITS'(10);
  localparam logic [WIDE_BITS-1:0]   MAX_AVG_RESET = WIDE_BITS'(512);

  // register index, taken from paddr[3:2]
  typedef enum logic [1:0] {
    REG_DC_OFFSET   = 2'd0,
    REG_NOISE_LEVEL = 2'd1,
    REG_MIN_SPREAD  = 2'd2,
    REG_UNUSED      = 2'd3
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_OFFSET,
    ST_GATE,
    ST_STORE,
    ST_SCAN,
    ST_DRAIN,
    ST_SPREAD,
    ST_AVG_LO,
    ST_AVG_HI,
    ST_DONE
  } state_t;

  // (63*avg + x) >> 6
  function automatic logic [WIDE_BITS-1:0] damp64(input logic [WIDE_BITS-1:0] avg,
                                                  input logic [WIDE_BITS-1:0] x);
    logic [WIDE_BITS+6:0] acc;
    acc = (WIDE_BITS + 7)'({avg, 6'b000000}) - (WIDE_BITS + 7)'(avg)
          + (WIDE_BITS + 7)'(x);
    return acc[WIDE_BITS+5:6];
  endfunction

endpackage

FILE: hdl/audio_level_tracker.sv
// top level of the audio level tracker: sequencer, window memory and shared datapath
//
// One sample request in gives one result request out. Each sample walks a small
// sequencer: offset removal, noise gate, smoothing plus window write, then a serial
// min/max scan of the window through its single registered read port (one entry per
// cycle), spread enforcement and two 1/64 damping steps on a shared adder. A new
// sample cannot be accepted until the sequence, which includes the scan of the
// 60-entry window, has run through and the sequencer is back in idle: in_tready is
// high only while the sequencer idles. The finished result sits in an output
// register, so the next sample can be accepted while it waits for out_tready.
// Window entries not yet written since reset read as zero through a fill count,
// so no clearing pass is needed. Configuration registers must be written through
// the APB-style port only while the block is idle; the block itself does not
// enforce this.
module audio_level_tracker (
  input  logic                            clk,
  input  logic                            rst_n,
  // sample request
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [alt_pkg::IN_W-1:0]        in_tdata,     // [9:0] sample
  // result request
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [alt_pkg::OUT_W-1:0]       out_tdata,    // [9:0] raw_level, [19:10] smoothed_level,
                                                        // [29:20] min_level_avg, [40:30] max_level_avg
  // configuration
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [alt_pkg::ADDR_W-1:0]      cfg_paddr,
  input  logic [31:0]                     cfg_pwdata,
  output logic [31:0]                     cfg_prdata,
  output logic                            cfg_pready
);

  localparam int SB = alt_pkg::SAMPLE_BITS;
  localparam int WB = alt_pkg::WIDE_BITS;
  localparam int IW = alt_pkg::IDX_W;
  localparam int CW = alt_pkg::CNT_W;
  localparam logic [IW-1:0] LAST_IDX  = IW'(alt_pkg::WINDOW_DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT  = CW'(alt_pkg::WINDOW_DEPTH);

  // configuration registers
  logic [SB-1:0] dc_offset_r, noise_level_r, min_spread_r;
  alt_pkg::reg_idx_t cfg_idx;
  logic          cfg_wr;

  // sequencer
  alt_pkg::state_t state_r, state_nxt;

  // working registers
  logic [SB-1:0] raw_r, raw_nxt;
  logic [SB-1:0] n_r, n_nxt;
  logic [SB-1:0] smooth_r, smooth_nxt;
  logic [SB-1:0] min_avg_r, min_avg_nxt;
  logic [WB-1:0] max_avg_r, max_avg_nxt;
  logic [SB-1:0] lo_r, lo_nxt;
  logic [WB-1:0] hi_r, hi_nxt;
  logic [IW-1:0] slot_r, slot_nxt;
  logic [CW-1:0] fill_r, fill_nxt;
  logic [IW-1:0] rd_addr_r, rd_addr_nxt;

  // window memory and its registered read
  logic [SB-1:0] window_mem [alt_pkg::WINDOW_DEPTH];
  logic [SB-1:0] mem_q_r;
  logic [IW-1:0] q_idx_r;
  logic          q_vld_r;
  logic          mem_we;

  // result register
  logic                       out_vld_r, out_vld_nxt;
  logic [alt_pkg::OUT_W-1:0]  out_data_r, out_data_nxt;

  // shared alu and helpers
  logic [SB-1:0] alu_a, alu_b;
  logic [SB:0]   alu_diff;
  logic [WB-1:0] damp_avg, damp_x, damp_res;
  logic [SB+3:0] smooth_acc;
  logic [SB-1:0] scan_val;
  logic [WB-1:0] spread_sum;
  logic [SB-1:0] spread_gap;
  logic          in_acc, out_acc;

  assign in_acc  = in_tvalid & in_tready;
  assign out_acc = out_tvalid & out_tready;

  // ---------------- configuration port ----------------
  assign cfg_pready = 1'b1;
  assign cfg_idx    = alt_pkg::reg_idx_t'(cfg_paddr[3:2]);
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_comb begin
    unique case (cfg_idx)
      alt_pkg::REG_DC_OFFSET:   cfg_prdata = 32'(dc_offset_r);
      alt_pkg::REG_NOISE_LEVEL: cfg_prdata = 32'(noise_level_r);
      alt_pkg::REG_MIN_SPREAD:  cfg_prdata = 32'(min_spread_r);
      default:                  cfg_prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dc_offset_r   <= '0;
      noise_level_r <= alt_pkg::NOISE_RESET;
      min_spread_r  <= alt_pkg::SPREAD_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        alt_pkg::REG_DC_OFFSET:   dc_offset_r   <= cfg_pwdata[SB-1:0];
        alt_pkg::REG_NOISE_LEVEL: noise_level_r <= cfg_pwdata[SB-1:0];
        alt_pkg::REG_MIN_SPREAD:  min_spread_r  <= cfg_pwdata[SB-1:0];
        default: ;
      endcase
    end
  end

  // ---------------- shared arithmetic ----------------
  // subtractor with borrow in the top bit
  always_comb begin
    alu_a = n_r;
    alu_b = noise_level_r;
    if (state_r == alt_pkg::ST_OFFSET) begin
      alu_a = raw_r;
      alu_b = dc_offset_r;
    end
  end
  assign alu_diff = {1'b0, alu_a} - {1'b0, alu_b};

  // one damping adder shared by the min and max averages
  assign damp_avg = (state_r == alt_pkg::ST_AVG_HI) ? max_avg_r : WB'(min_avg_r);
  assign damp_x   = (state_r == alt_pkg::ST_AVG_HI) ? hi_r : WB'(lo_r);
  assign damp_res = alt_pkg::damp64(damp_avg, damp_x);

  // (7*lvl + n) >> 3
  assign smooth_acc = (SB + 4)'({smooth_r, 3'b000}) - (SB + 4)'(smooth_r) + (SB + 4)'(n_r);

  // never-written entries read as zero
  assign scan_val   = (CW'(q_idx_r) < fill_r) ? mem_q_r : '0;
  assign spread_sum = WB'(lo_r) + WB'(min_spread_r);
  assign spread_gap = hi_r[SB-1:0] - lo_r;

  // ---------------- sequencer: next state ----------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      alt_pkg::ST_IDLE:   if (in_acc) state_nxt = alt_pkg::ST_OFFSET;
      alt_pkg::ST_OFFSET: state_nxt = alt_pkg::ST_GATE;
      alt_pkg::ST_GATE:   state_nxt = alt_pkg::ST_STORE;
      alt_pkg::ST_STORE:  state_nxt = alt_pkg::ST_SCAN;
      alt_pkg::ST_SCAN:   if (rd_addr_r == LAST_IDX) state_nxt = alt_pkg::ST_DRAIN;
      alt_pkg::ST_DRAIN:  state_nxt = alt_pkg::ST_SPREAD;
      alt_pkg::ST_SPREAD: state_nxt = alt_pkg::ST_AVG_LO;
      alt_pkg::ST_AVG_LO: state_nxt = alt_pkg::ST_AVG_HI;
      alt_pkg::ST_AVG_HI: state_nxt = alt_pkg::ST_DONE;
      alt_pkg::ST_DONE:   if (!out_vld_r || out_tready) state_nxt = alt_pkg::ST_IDLE;
      default:            state_nxt = alt_pkg::ST_IDLE;
    endcase
  end

  // ---------------- sequencer: outputs and datapath ----------------
  always_comb begin
    in_tready    = (state_r == alt_pkg::ST_IDLE);
    mem_we       = 1'b0;
    raw_nxt      = raw_r;
    n_nxt        = n_r;
    smooth_nxt   = smooth_r;
    min_avg_nxt  = min_avg_r;
    max_avg_nxt  = max_avg_r;
    lo_nxt       = lo_r;
    hi_nxt       = hi_r;
    slot_nxt     = slot_r;
    fill_nxt     = fill_r;
    rd_addr_nxt  = rd_addr_r;
    out_vld_nxt  = out_vld_r & ~out_tready;
    out_data_nxt = out_data_r;

    // min/max compare on the registered read data
    if (q_vld_r) begin
      if (q_idx_r == '0) begin
        lo_nxt = scan_val;
        hi_nxt = WB'(scan_val);
      end else begin
        if (scan_val < lo_r) lo_nxt = scan_val;
        if (WB'(scan_val) > hi_r) hi_nxt = WB'(scan_val);
      end
    end

    unique case (state_r)
      alt_pkg::ST_IDLE: begin
        if (in_acc) raw_nxt = in_tdata[SB-1:0];
      end
      alt_pkg::ST_OFFSET: begin
        n_nxt = alu_diff[SB] ? '0 : alu_diff[SB-1:0];
      end
      alt_pkg::ST_GATE: begin
        // at or below the noise level gates to zero
        n_nxt = (alu_diff[SB] || alu_diff == '0) ? '0 : alu_diff[SB-1:0];
      end
      alt_pkg::ST_STORE: begin
        mem_we      = 1'b1;
        smooth_nxt  = smooth_acc[SB+2:3];
        slot_nxt    = (slot_r == LAST_IDX) ? '0 : slot_r + IW'(1);
        if (fill_r != FULL_CNT) fill_nxt = fill_r + CW'(1);
        rd_addr_nxt = '0;
      end
      alt_pkg::ST_SCAN: begin
        if (rd_addr_r != LAST_IDX) rd_addr_nxt = rd_addr_r + IW'(1);
      end
      alt_pkg::ST_DRAIN: ;
      alt_pkg::ST_SPREAD: begin
        if (spread_gap < min_spread_r) hi_nxt = spread_sum;
      end
      alt_pkg::ST_AVG_LO: begin
        min_avg_nxt = damp_res[SB-1:0];
      end
      alt_pkg::ST_AVG_HI: begin
        max_avg_nxt = damp_res;
      end
      alt_pkg::ST_DONE: begin
        if (!out_vld_r || out_tready) begin
          out_vld_nxt  = 1'b1;
          out_data_nxt = alt_pkg::OUT_W'({max_avg_r, min_avg_r, smooth_r, raw_r});
        end
      end
      default: ;
    endcase
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

  // ---------------- window memory ----------------
  always_ff @(posedge clk) begin
    if (mem_we) window_mem[slot_r] <= n_r;
    mem_q_r <= window_mem[rd_addr_r];
    q_idx_r <= rd_addr_r;
  end

  // ---------------- registers ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= alt_pkg::ST_IDLE;
      smooth_r  <= alt_pkg::SMOOTH_RESET;
      min_avg_r <= '0;
      max_avg_r <= alt_pkg::MAX_AVG_RESET;
      slot_r    <= '0;
      fill_r    <= '0;
      rd_addr_r <= '0;
      q_vld_r   <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      smooth_r  <= smooth_nxt;
      min_avg_r <= min_avg_nxt;
      max_avg_r <= max_avg_nxt;
      slot_r    <= slot_nxt;
      fill_r    <= fill_nxt;
      rd_addr_r <= rd_addr_nxt;
      q_vld_r   <= (state_r == alt_pkg::ST_SCAN);
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    raw_r      <= raw_nxt;
    n_r        <= n_nxt;
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    out_data_r <= out_data_nxt;
  end

  // ---------------- assertions ----------------
`ifndef SYNTH
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FULL_CNT)
    else $error("window fill count beyond depth");

  a_slot_tracks_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (fill_r != FULL_CNT) |-> (CW'(slot_r) == fill_r))
    else $error("write slot and fill count disagree before the window fills");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_vld_r) |-> $past(state_r == alt_pkg::ST_DONE))
    else $error("result raised outside the final step");

  a_accept_starts_work: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == alt_pkg::ST_OFFSET))
    else $error("accepted sample did not start the sequence");

  a_scan_ends_last: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == alt_pkg::ST_DRAIN) |-> (q_vld_r && q_idx_r == LAST_IDX))
    else $error("window scan did not end on the last entry");
`endif

endmodule
